@@ rtl/bfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Buffer fan-out reference counter package
// Shared widths, result codes, the entry layout and the sequencer microcode.
// ----------------------------------------------------------------------------
package bfrc_pkg;

   localparam int MASK_W            = 8;
   localparam int ADDR_W            = 32;
   localparam int COUNT_W           = 4;
   localparam int CH_W              = 3;
   localparam int CSR_IDX_W         = 1;
   localparam int DEF_CHANNELS      = 8;
   localparam int DEF_MAX_IN_FLIGHT = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED_MASK   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECTED_MASK = 1'd1;

   typedef enum logic [1:0] {
      KIND_COPY   = 2'd0,
      KIND_RETURN = 2'd1,
      KIND_FAULT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE       = 2'd0,
      FAULT_UNKNOWN    = 2'd1,
      FAULT_IN_FLIGHT  = 2'd2,
      FAULT_TABLE_FULL = 2'd3
   } fault_type;

   // Microcode step addresses.
   typedef enum logic [4:0] {
      STEP_IDLE      = 5'd0,
      STEP_DISPATCH  = 5'd1,
      STEP_SEND_CHK  = 5'd2,
      STEP_SEND_SCAN = 5'd3,
      STEP_SEND_WAIT = 5'd4,
      STEP_SEND_HIT  = 5'd5,
      STEP_SEND_FREE = 5'd6,
      STEP_SEND_INS  = 5'd7,
      STEP_COPY      = 5'd8,
      STEP_RET_SCAN  = 5'd9,
      STEP_RET_WAIT  = 5'd10,
      STEP_RET_HIT   = 5'd11,
      STEP_RET_CNT   = 5'd12,
      STEP_RET_DEC   = 5'd13,
      STEP_RET_FREE  = 5'd14,
      STEP_EMIT_RET  = 5'd15,
      STEP_FAULT_DUP = 5'd16,
      STEP_FAULT_FUL = 5'd17,
      STEP_FAULT_UNK = 5'd18
   } step_type;

   typedef enum logic [3:0] {
      ACT_NONE         = 4'd0,
      ACT_ACCEPT       = 4'd1,
      ACT_SCAN_START   = 4'd2,
      ACT_INSERT       = 4'd3,
      ACT_COPY_STEP    = 4'd4,
      ACT_DECREMENT    = 4'd5,
      ACT_RELEASE      = 4'd6,
      ACT_EMIT_RETURN  = 4'd7,
      ACT_EMIT_DUP     = 4'd8,
      ACT_EMIT_FULL    = 4'd9,
      ACT_EMIT_UNKNOWN = 4'd10
   } act_type;

   typedef enum logic [3:0] {
      COND_ALWAYS    = 4'd0,
      COND_REQ_VALID = 4'd1,
      COND_IS_RETURN = 4'd2,
      COND_NO_ACTIVE = 4'd3,
      COND_SCAN_BUSY = 4'd4,
      COND_HIT       = 4'd5,
      COND_NO_FREE   = 4'd6,
      COND_CNT_LE1   = 4'd7,
      COND_COPY_MORE = 4'd8,
      COND_OUT_BUSY  = 4'd9
   } cond_type;

   // One control word: the action for this step, then a jump taken when the
   // condition holds and the word's other successor step otherwise.
   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type jmp;
      step_type nxt;
   } ctl_word_type;

   typedef struct packed {
      logic req_valid;
      logic is_return;
      logic no_active;
      logic scan_busy;
      logic hit;
      logic no_free;
      logic cnt_le1;
      logic copy_more;
      logic out_busy;
   } cond_flags_type;

   typedef struct packed {
      logic busy;
      logic hit;
      logic free_found;
   } scan_status_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
   } entry_type;

   function automatic ctl_word_type cw(act_type act, cond_type cond,
                                       step_type jmp, step_type nxt);
      ctl_word_type w;
      w.act  = act;
      w.cond = cond;
      w.jmp  = jmp;
      w.nxt  = nxt;
      return w;
   endfunction

   function automatic ctl_word_type bfrc_microcode(step_type step);
      ctl_word_type w;
      unique case (step)
         STEP_IDLE:      w = cw(ACT_ACCEPT, COND_REQ_VALID, STEP_DISPATCH, STEP_IDLE);
         STEP_DISPATCH:  w = cw(ACT_NONE, COND_IS_RETURN, STEP_RET_SCAN, STEP_SEND_CHK);
         STEP_SEND_CHK:  w = cw(ACT_NONE, COND_NO_ACTIVE, STEP_EMIT_RET, STEP_SEND_SCAN);
         STEP_SEND_SCAN: w = cw(ACT_SCAN_START, COND_ALWAYS, STEP_SEND_WAIT, STEP_SEND_WAIT);
         STEP_SEND_WAIT: w = cw(ACT_NONE, COND_SCAN_BUSY, STEP_SEND_WAIT, STEP_SEND_HIT);
         STEP_SEND_HIT:  w = cw(ACT_NONE, COND_HIT, STEP_FAULT_DUP, STEP_SEND_FREE);
         STEP_SEND_FREE: w = cw(ACT_NONE, COND_NO_FREE, STEP_FAULT_FUL, STEP_SEND_INS);
         STEP_SEND_INS:  w = cw(ACT_INSERT, COND_ALWAYS, STEP_COPY, STEP_COPY);
         STEP_COPY:      w = cw(ACT_COPY_STEP, COND_COPY_MORE, STEP_COPY, STEP_IDLE);
         STEP_RET_SCAN:  w = cw(ACT_SCAN_START, COND_ALWAYS, STEP_RET_WAIT, STEP_RET_WAIT);
         STEP_RET_WAIT:  w = cw(ACT_NONE, COND_SCAN_BUSY, STEP_RET_WAIT, STEP_RET_HIT);
         STEP_RET_HIT:   w = cw(ACT_NONE, COND_HIT, STEP_RET_CNT, STEP_FAULT_UNK);
         STEP_RET_CNT:   w = cw(ACT_NONE, COND_CNT_LE1, STEP_RET_FREE, STEP_RET_DEC);
         STEP_RET_DEC:   w = cw(ACT_DECREMENT, COND_ALWAYS, STEP_IDLE, STEP_IDLE);
         STEP_RET_FREE:  w = cw(ACT_RELEASE, COND_ALWAYS, STEP_EMIT_RET, STEP_EMIT_RET);
         STEP_EMIT_RET:  w = cw(ACT_EMIT_RETURN, COND_OUT_BUSY, STEP_EMIT_RET, STEP_IDLE);
         STEP_FAULT_DUP: w = cw(ACT_EMIT_DUP, COND_OUT_BUSY, STEP_FAULT_DUP, STEP_IDLE);
         STEP_FAULT_FUL: w = cw(ACT_EMIT_FULL, COND_OUT_BUSY, STEP_FAULT_FUL, STEP_IDLE);
         STEP_FAULT_UNK: w = cw(ACT_EMIT_UNKNOWN, COND_OUT_BUSY, STEP_FAULT_UNK, STEP_IDLE);
         default:        w = cw(ACT_NONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

@@ rtl/bfrc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfrc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bfrc_scan.sv @@
// ----------------------------------------------------------------------------
// Table scan unit
// Walks the entry RAM one entry per cycle looking for a matching address and
// remembering the lowest free slot on the way.
// ----------------------------------------------------------------------------
module bfrc_scan #(
   parameter int MAX_IN_FLIGHT = bfrc_pkg::DEF_MAX_IN_FLIGHT,
   localparam int IDX_W = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bfrc_pkg::ADDR_W-1:0]      key_addr,
   input  logic [MAX_IN_FLIGHT-1:0]         entry_valid,
   input  bfrc_pkg::entry_type              rd_data,
   output logic [IDX_W-1:0]                 rd_addr,
   output bfrc_pkg::scan_status_type        status,
   output logic [IDX_W-1:0]                 hit_idx,
   output logic [bfrc_pkg::COUNT_W-1:0]     hit_count,
   output logic [IDX_W-1:0]                 free_idx
);

   import bfrc_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_IN_FLIGHT - 1);

   logic               busy_ff, busy_in;
   logic               issue_ff, issue_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               hit_ff, hit_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0] hit_count_ff, hit_count_in;
   logic               slot_valid;
   logic               match;

   // The RAM returns the entry addressed in the previous cycle, which is the one
   // tracked by the compare index.
   assign slot_valid = entry_valid[cmp_idx_ff];
   assign match      = cmp_vld_ff && slot_valid && (rd_data.addr == key_addr);

   always_comb begin
      busy_in       = busy_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = rd_idx_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      hit_count_in  = hit_count_ff;
      if (start) begin
         busy_in       = 1'b1;
         issue_in      = 1'b1;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
         rd_idx_in     = '0;
      end else if (busy_ff) begin
         cmp_vld_in = issue_ff;
         if (issue_ff) begin
            if (rd_idx_ff == LAST_IDX) begin
               issue_in = 1'b0;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         if (cmp_vld_ff) begin
            if (!slot_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (match) begin
               hit_in       = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_count_in = rd_data.count;
               busy_in      = 1'b0;
               issue_in     = 1'b0;
               cmp_vld_in   = 1'b0;
            end else if (cmp_idx_ff == LAST_IDX) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         issue_ff      <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
      end
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      hit_count_ff <= hit_count_in;
   end

   assign rd_addr           = rd_idx_ff;
   assign status.busy       = busy_ff;
   assign status.hit        = hit_ff;
   assign status.free_found = free_found_ff;
   assign hit_idx           = hit_idx_ff;
   assign hit_count         = hit_count_ff;
   assign free_idx          = free_idx_ff;

endmodule

@@ rtl/bfrc_seq.sv @@
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control store with a conditional jump per step.
// ----------------------------------------------------------------------------
module bfrc_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  bfrc_pkg::cond_flags_type flags,
   output bfrc_pkg::act_type        act
);

   import bfrc_pkg::*;

   step_type     step_ff, step_in;
   ctl_word_type word;
   logic         take;

   assign word = bfrc_microcode(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_ALWAYS:    take = 1'b1;
         COND_REQ_VALID: take = flags.req_valid;
         COND_IS_RETURN: take = flags.is_return;
         COND_NO_ACTIVE: take = flags.no_active;
         COND_SCAN_BUSY: take = flags.scan_busy;
         COND_HIT:       take = flags.hit;
         COND_NO_FREE:   take = flags.no_free;
         COND_CNT_LE1:   take = flags.cnt_le1;
         COND_COPY_MORE: take = flags.copy_more;
         COND_OUT_BUSY:  take = flags.out_busy;
         default:        take = 1'b1;
      endcase
      step_in = take ? word.jmp : word.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign act = word.act;

endmodule

@@ rtl/buffer_fanout_refcount_table.sv @@
// Order of work: a send with no active channel is returned without a scan; any other send
// scans the table, inserts an entry, then walks the channels one channel position a cycle,
// holding on an active one while the output stalls. A return scans the table; the last one
// frees the entry and is returned, others only decrement. Faults: held, table full, unknown.
// Throughput: one item at a time, set by the table scan (one entry a cycle) and the copy walk.
// Reset: synchronous; clears the valid bits, sets both masks to all ones, idles the sequencer.
// ----------------------------------------------------------------------------
// Buffer fan-out reference counter
// Tracks buffers copied to several channels and returns each to its source
// once every channel has handed it back.
// ----------------------------------------------------------------------------
module buffer_fanout_refcount_table #(
   parameter int CHANNELS      = bfrc_pkg::DEF_CHANNELS,
   parameter int MAX_IN_FLIGHT = bfrc_pkg::DEF_MAX_IN_FLIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [bfrc_pkg::ADDR_W-1:0]      req_buffer_addr,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [bfrc_pkg::CH_W-1:0]        rsp_channel,
   output logic [bfrc_pkg::ADDR_W-1:0]      rsp_out_addr,
   output logic [1:0]                       rsp_fault_code,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bfrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfrc_pkg::MASK_W-1:0]      csr_wdata
);

   import bfrc_pkg::*;

   localparam int IDX_W = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1;
   localparam int NCH   = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
   localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((1 << NCH) - 1);

   act_type         act;
   cond_flags_type  flags;
   scan_status_type scan_status;

   logic [MASK_W-1:0]        enabled_ff, connected_ff;
   logic                     op_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [MAX_IN_FLIGHT-1:0] valid_ff;
   logic [CH_W-1:0]          ch_ff, ch_in;

   logic [MASK_W-1:0]  active;
   logic [MASK_W-1:0]  higher;
   logic [COUNT_W-1:0] active_count;
   logic               ch_active;
   logic               out_busy;
   logic               advance;

   logic [IDX_W-1:0]   rd_addr, hit_idx, free_idx;
   logic [COUNT_W-1:0] hit_count;
   entry_type          rd_data, wr_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;

   logic               emit;
   kind_type           emit_kind;
   fault_type          emit_fault;
   logic [CH_W-1:0]    emit_ch;
   logic               emit_last;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff;
   fault_type          rsp_fault_ff;
   logic [CH_W-1:0]    rsp_channel_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic               rsp_last_ff;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= '1;
         connected_ff <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLED_MASK:   enabled_ff   <= csr_wdata;
            CSR_CONNECTED_MASK: connected_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Channel selection
   // ------------------------------------------------------------------------
   assign active    = enabled_ff & connected_ff & CH_MASK;
   assign ch_active = active[ch_ff];

   always_comb begin
      active_count = '0;
      for (int i = 0; i < MASK_W; i++) begin
         active_count = active_count + COUNT_W'(active[i]);
         higher[i]    = active[i] && (CH_W'(i) > ch_ff);
      end
   end

   assign out_busy = rsp_valid_ff && rsp_stall;
   // Inactive channels are skipped without waiting for the output register.
   assign advance  = !ch_active || !out_busy;

   always_comb begin
      ch_in = ch_ff;
      if (act == ACT_INSERT) begin
         ch_in = '0;
      end else if (act == ACT_COPY_STEP && advance) begin
         ch_in = ch_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Item registers and entry valid bits
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (act == ACT_ACCEPT && req_valid) begin
         op_ff   <= req_op;
         addr_ff <= req_buffer_addr;
      end
      ch_ff <= ch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (act == ACT_INSERT) begin
         valid_ff[free_idx] <= 1'b1;
      end else if (act == ACT_RELEASE) begin
         valid_ff[hit_idx] <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Entry table
   // ------------------------------------------------------------------------
   assign wr_en        = (act == ACT_INSERT) || (act == ACT_DECREMENT);
   assign wr_addr      = (act == ACT_INSERT) ? free_idx : hit_idx;
   assign wr_data.addr = addr_ff;
   assign wr_data.count = (act == ACT_INSERT) ? active_count : (hit_count - 1'b1);

   bfrc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_IN_FLIGHT)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bfrc_scan #(
      .MAX_IN_FLIGHT (MAX_IN_FLIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (act == ACT_SCAN_START),
      .key_addr    (addr_ff),
      .entry_valid (valid_ff),
      .rd_data     (rd_data),
      .rd_addr     (rd_addr),
      .status      (scan_status),
      .hit_idx     (hit_idx),
      .hit_count   (hit_count),
      .free_idx    (free_idx)
   );

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   assign flags.req_valid = req_valid;
   assign flags.is_return = op_ff;
   assign flags.no_active = (active == '0);
   assign flags.scan_busy = scan_status.busy;
   assign flags.hit       = scan_status.hit;
   assign flags.no_free   = !scan_status.free_found;
   assign flags.cnt_le1   = (hit_count <= COUNT_W'(1));
   assign flags.copy_more = !(advance && (higher == '0));
   assign flags.out_busy  = out_busy;

   bfrc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .act   (act)
   );

   assign req_stall = (act != ACT_ACCEPT);

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   always_comb begin
      emit       = 1'b0;
      emit_kind  = KIND_FAULT;
      emit_fault = FAULT_NONE;
      emit_ch    = '0;
      emit_last  = 1'b1;
      unique case (act)
         ACT_COPY_STEP: begin
            emit      = ch_active && !out_busy;
            emit_kind = KIND_COPY;
            emit_ch   = ch_ff;
            emit_last = (higher == '0);
         end
         ACT_EMIT_RETURN: begin
            emit      = !out_busy;
            emit_kind = KIND_RETURN;
         end
         ACT_EMIT_DUP: begin
            emit       = !out_busy;
            emit_fault = FAULT_IN_FLIGHT;
         end
         ACT_EMIT_FULL: begin
            emit       = !out_busy;
            emit_fault = FAULT_TABLE_FULL;
         end
         ACT_EMIT_UNKNOWN: begin
            emit       = !out_busy;
            emit_fault = FAULT_UNKNOWN;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_kind_ff    <= emit_kind;
         rsp_fault_ff   <= emit_fault;
         rsp_channel_ff <= emit_ch;
         rsp_addr_ff    <= addr_ff;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_out_addr   = rsp_addr_ff;
   assign rsp_fault_code = rsp_fault_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ rtl/bfrc_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the fan-out reference counter for illegal behavior.
// ----------------------------------------------------------------------------
module bfrc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [1:0]                       rsp_kind,
   input logic [bfrc_pkg::CH_W-1:0]        rsp_channel,
   input logic [bfrc_pkg::ADDR_W-1:0]      rsp_out_addr,
   input logic [1:0]                       rsp_fault_code,
   input logic                             rsp_last
);

   import bfrc_pkg::*;

   // A stalled result holds until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_addr) &&
         $stable(rsp_kind) && $stable(rsp_channel) && $stable(rsp_last))
      else $error("stalled result changed");

   // Only one item is in work: the cycle after a transfer the input is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted back to back");

   // Fault code is set exactly on fault results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_FAULT) == (rsp_fault_code != FAULT_NONE)))
      else $error("fault code does not match result kind");

   // Returns and faults are single results on channel zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_COPY) |-> rsp_last && (rsp_channel == '0))
      else $error("non-copy result not final or not on channel zero");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind buffer_fanout_refcount_table bfrc_checker u_bfrc_checker (.*);
